// ===== sv/geohash_encoder_assert.svh =====
// Assertion macros shared by the geohash encoder checkers.
// GHE_ASSERT samples on the rising clock edge and is switched off during reset.
// GHE_ASSERT_RST samples on the rising clock edge and stays active during reset.
`ifndef GEOHASH_ENCODER_ASSERT_SVH
`define GEOHASH_ENCODER_ASSERT_SVH

`define GHE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define GHE_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ghe_pkg.sv =====
`timescale 1ns / 1ps

package ghe_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned CHAR_W = 5;
	localparam int unsigned BITS_PER_CHAR = 5;
	localparam int unsigned SYMBOL_W = 7;
	localparam logic [CHAR_W-1:0] CHAR_COUNT_RESET = 5'd12;
	localparam int unsigned FALLBACK_CHARS = 12;
	localparam logic [COORD_W-1:0] BIAS_M1 = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [COORD_W-1:0] lat_fraction;
		logic signed [COORD_W-1:0] lon_fraction;
	} in_item_t;

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic last_symbol;
	} out_item_t;

	function automatic logic [SYMBOL_W-1:0] base32_char(input logic [BITS_PER_CHAR-1:0] code);
		logic [SYMBOL_W-1:0] c;
		unique case (code)
			5'd0: c = 7'h30;
			5'd1: c = 7'h31;
			5'd2: c = 7'h32;
			5'd3: c = 7'h33;
			5'd4: c = 7'h34;
			5'd5: c = 7'h35;
			5'd6: c = 7'h36;
			5'd7: c = 7'h37;
			5'd8: c = 7'h38;
			5'd9: c = 7'h39;
			5'd10: c = 7'h62;
			5'd11: c = 7'h63;
			5'd12: c = 7'h64;
			5'd13: c = 7'h65;
			5'd14: c = 7'h66;
			5'd15: c = 7'h67;
			5'd16: c = 7'h68;
			5'd17: c = 7'h6A;
			5'd18: c = 7'h6B;
			5'd19: c = 7'h6D;
			5'd20: c = 7'h6E;
			5'd21: c = 7'h70;
			5'd22: c = 7'h71;
			5'd23: c = 7'h72;
			5'd24: c = 7'h73;
			5'd25: c = 7'h74;
			5'd26: c = 7'h75;
			5'd27: c = 7'h76;
			5'd28: c = 7'h77;
			5'd29: c = 7'h78;
			5'd30: c = 7'h79;
			5'd31: c = 7'h7A;
			default: c = 7'h30;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/geohash_encoder.sv =====
`timescale 1ns / 1ps
// Geohash encoder: turns one latitude/longitude pair into its base32 geohash.
// Input channel (in_valid/in_ready/in_data): one coordinate pair per transfer, both
// coordinates as signed 32-bit fractions of 90 and 180 degrees respectively.
// Output channel (out_valid/out_ready/out_data): one ASCII character per transfer,
// most significant character first, with last_symbol set on the final one.
// cfg_wr_en/cfg_wr_data set the character count; 0 or more than MAX_CHARS selects 12, or MAX_CHARS if smaller.
// The count is sampled when a coordinate pair is taken in.
// The first character is offered once the pair has passed s1, s2 and s3 and been
// loaded into the character shifter. An item occupies the output for one transfer per
// character (12 by default, up to MAX_CHARS), sent by the character shifter.
// A three-stage pipeline feeds the shifter, so the next item is taken in while the
// current one is still being sent, and it follows the last character without a gap.
// When the receiver stalls, the character on offer holds and the pipeline fills up
// and then holds its contents; nothing is lost or sent twice.
// Reset empties the pipeline and the shifter and sets the character count to 12.

module geohash_encoder #(
	parameter int unsigned MAX_CHARS = 20
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ghe_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output ghe_pkg::out_item_t out_data,
	input logic cfg_wr_en,
	input logic [ghe_pkg::CHAR_W-1:0] cfg_wr_data
);

	localparam int unsigned WORD_W = ghe_pkg::BITS_PER_CHAR * MAX_CHARS;
	localparam int unsigned LON_BITS = (WORD_W + 1) / 2;
	localparam int unsigned LAT_BITS = WORD_W / 2;
	localparam int unsigned FALLBACK = (ghe_pkg::FALLBACK_CHARS < MAX_CHARS) ?
		ghe_pkg::FALLBACK_CHARS : MAX_CHARS;
	localparam int unsigned CW = ghe_pkg::CHAR_W;
	localparam int unsigned XW = ghe_pkg::COORD_W;
	localparam int unsigned BW = ghe_pkg::BITS_PER_CHAR;

	logic [CW-1:0] char_count_q;

	logic valid_s1, valid_s2, valid_s3;
	logic [XW-1:0] lat_s1, lon_s1;
	logic [CW-1:0] count_s1, count_s2, count_s3;
	logic [XW-1:0] lat_v_s2, lon_v_s2;
	logic lat_min_s2, lon_min_s2;
	logic [WORD_W-1:0] word_s3;

	logic ser_valid_q;
	logic [WORD_W-1:0] word_q;
	logic [CW-1:0] left_q;

	logic take1, take2, take3, ser_load, last;
	logic [CW-1:0] count_sel;
	logic [LON_BITS-1:0] lon_axis;
	logic [LAT_BITS-1:0] lat_axis;
	logic [WORD_W-1:0] word_next;

	assign last = (left_q == CW'(1));
	assign ser_load = valid_s3 && (!ser_valid_q || (out_ready && last));
	assign take3 = !valid_s3 || ser_load;
	assign take2 = !valid_s2 || take3;
	assign take1 = !valid_s1 || take2;
	assign in_ready = take1;

	assign count_sel = (char_count_q == '0 || char_count_q > CW'(MAX_CHARS)) ?
		CW'(FALLBACK) : char_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= ghe_pkg::CHAR_COUNT_RESET;
		end else if (cfg_wr_en) begin
			char_count_q <= cfg_wr_data;
		end
	end

	// Each axis is bisected exactly, and a bit is set only strictly above the midpoint,
	// so an axis yields the bits of (code + 2^31 - 1) followed by ones, or all zeros
	// for the most negative code.
	genvar gi;
	generate
		for (gi = 0; gi < LON_BITS; gi++) begin : g_lon
			if (gi < XW) begin : g_int
				assign lon_axis[LON_BITS-1-gi] = !lon_min_s2 && lon_v_s2[XW-1-gi];
			end else begin : g_frac
				assign lon_axis[LON_BITS-1-gi] = !lon_min_s2;
			end
		end
		for (gi = 0; gi < LAT_BITS; gi++) begin : g_lat
			if (gi < XW) begin : g_int
				assign lat_axis[LAT_BITS-1-gi] = !lat_min_s2 && lat_v_s2[XW-1-gi];
			end else begin : g_frac
				assign lat_axis[LAT_BITS-1-gi] = !lat_min_s2;
			end
		end
		for (gi = 0; gi < WORD_W; gi++) begin : g_mix
			if (gi % 2 == 0) begin : g_even
				assign word_next[WORD_W-1-gi] = lon_axis[LON_BITS-1-gi/2];
			end else begin : g_odd
				assign word_next[WORD_W-1-gi] = lat_axis[LAT_BITS-1-gi/2];
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (take1) begin
				valid_s1 <= in_valid;
			end
			if (take2) begin
				valid_s2 <= valid_s1;
			end
			if (take3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take1 && in_valid) begin
			lat_s1 <= in_data.lat_fraction;
			lon_s1 <= in_data.lon_fraction;
			count_s1 <= count_sel;
		end
		if (take2 && valid_s1) begin
			lat_v_s2 <= lat_s1 + ghe_pkg::BIAS_M1;
			lon_v_s2 <= lon_s1 + ghe_pkg::BIAS_M1;
			lat_min_s2 <= (lat_s1 == ghe_pkg::COORD_MIN);
			lon_min_s2 <= (lon_s1 == ghe_pkg::COORD_MIN);
			count_s2 <= count_s1;
		end
		if (take3 && valid_s2) begin
			word_s3 <= word_next;
			count_s3 <= count_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
		end else if (ser_load) begin
			ser_valid_q <= 1'b1;
		end else if (ser_valid_q && out_ready && last) begin
			ser_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			word_q <= word_s3;
			left_q <= count_s3;
		end else if (ser_valid_q && out_ready) begin
			word_q <= word_q << BW;
			left_q <= left_q - CW'(1);
		end
	end

	assign out_valid = ser_valid_q;
	assign out_data.symbol = ghe_pkg::base32_char(word_q[WORD_W-1 -: BW]);
	assign out_data.last_symbol = last;

endmodule

// ===== sv/ghe_checker.sv =====
`timescale 1ns / 1ps
`include "geohash_encoder_assert.svh"

module ghe_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input ghe_pkg::out_item_t out_data
);

	`GHE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled character changed")
	`GHE_ASSERT(a_in_stall_cause, !in_ready |-> out_valid, "input stalled while the output is empty")
	`GHE_ASSERT(a_symbol_legal, out_valid |-> out_data.symbol >= 7'h30 && out_data.symbol <= 7'h7A && out_data.symbol != 7'h61 && out_data.symbol != 7'h69 && out_data.symbol != 7'h6C && out_data.symbol != 7'h6F, "character outside the base32 alphabet")
	`GHE_ASSERT_RST(a_reset_empty, !arst_n |-> !out_valid, "output offered during reset")

endmodule

bind geohash_encoder ghe_checker u_ghe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
